/* design/strict_utf8_decoder_assert.svh */
// Assertion macros used by the checker module of the UTF-8 decoder
`ifndef STRICT_UTF8_DECODER_ASSERT_SVH
`define STRICT_UTF8_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SUD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sud check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SUD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sud check failed");

`endif

/* design/sud_pkg.sv */
// Shared constants and types of the strict UTF-8 decoder
`default_nettype none

package sud_pkg;

	localparam int CP_W  = 21;
	localparam int CNT_W = 3;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD3_LO    = 8'hE0;
	localparam logic [7:0] LEAD3_HI    = 8'hEF;
	localparam logic [7:0] LEAD3_SUR   = 8'hED;
	localparam logic [7:0] LEAD4_LO    = 8'hF0;
	localparam logic [7:0] LEAD4_HI    = 8'hF4;
	localparam logic [7:0] CONT_A0     = 8'hA0;
	localparam logic [7:0] CONT_90     = 8'h90;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
	localparam logic [CP_W-1:0] SUR_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] SUR_HI  = 21'h00DFFF;

	typedef struct packed {
		logic [7:0]  lead_byte;
		logic [1:0]  seen_count;
		logic [17:0] partial_value;
		logic        pending;
	} seq_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CP_W-1:0]  tail_cp;
		logic             tail_rep;
	} burst_t;

endpackage

`default_nettype wire

/* design/sud_ifs.sv */
// Valid/ready channel interfaces for text bytes and decoded code points
`default_nettype none

interface sud_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sud_cp_if import sud_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            replaced;
	logic            last_of_run;

	modport source (output valid, output code_point, output replaced, output last_of_run,
		input ready);
	modport sink (input valid, input code_point, input replaced, input last_of_run,
		output ready);
endinterface

`default_nettype wire

/* design/strict_utf8_decoder.sv */
// Strict UTF-8 decoder: one text byte in per item, zero to four code points out.
// The input is ready when the result register is empty, or when it holds the final
// code point of a run that the output takes in the same cycle, so bytes stream at
// one per cycle while the output keeps up. A byte that yields more than one code point
// (replacement bursts, up to four) holds the input until its final code point is taken,
// since the single result register issues one code point per cycle while the output
// is ready. Replacement items (U+FFFD, replaced=1) precede the final item of each
// run; last_of_run marks that final item.
`default_nettype none

module strict_utf8_decoder import sud_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	sud_byte_if.sink byte_in,
	sud_cp_if.source cp_out
);

	seq_state_t       st_q;
	seq_state_t       nst;
	burst_t           burst;
	logic [CNT_W-1:0] cnt_q;
	logic [CP_W-1:0]  tail_cp_q;
	logic             tail_rep_q;
	logic             in_fire;
	logic             out_fire;
	logic             is_last;

	sud_decode u_decode (
		.text_byte   (byte_in.text_byte),
		.end_of_text (byte_in.end_of_text),
		.st          (st_q),
		.nst         (nst),
		.burst       (burst)
	);

	assign is_last  = (cnt_q == 3'd1);
	assign out_fire = cp_out.valid && cp_out.ready;
	assign byte_in.ready = (cnt_q == 3'd0) || (is_last && cp_out.ready);
	assign in_fire  = byte_in.valid && byte_in.ready;

	assign cp_out.valid       = (cnt_q != 3'd0);
	assign cp_out.last_of_run = is_last;
	assign cp_out.code_point  = is_last ? tail_cp_q : REPL_CP;
	assign cp_out.replaced    = is_last ? tail_rep_q : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (in_fire) begin
				st_q  <= nst;
				cnt_q <= burst.count;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tail_cp_q  <= burst.tail_cp;
			tail_rep_q <= burst.tail_rep;
		end
	end

endmodule

`default_nettype wire

/* design/sud_decode.sv */
// Next-state and result-burst logic for one text byte
`default_nettype none

module sud_decode import sud_pkg::*; (
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	input  wire seq_state_t st,
	output seq_state_t      nst,
	output burst_t          burst
);

	logic        fit;
	logic        early_bad;
	logic [1:0]  need;
	logic [2:0]  step_cnt;
	logic [23:0] v;
	logic        fresh;

	always_comb begin
		early_bad = (st.seen_count == 2'd0) && (
			((st.lead_byte == LEAD3_LO)  && (text_byte <  CONT_A0)) ||
			((st.lead_byte == LEAD3_SUR) && (text_byte >= CONT_A0)) ||
			((st.lead_byte == LEAD4_LO)  && (text_byte <  CONT_90)) ||
			((st.lead_byte == LEAD4_HI)  && (text_byte >= CONT_90)));
		fit = ((text_byte & CONT_MASK) == CONT_TAG) && !early_bad;
		if (st.lead_byte >= LEAD4_LO) begin
			need = 2'd3;
		end else if (st.lead_byte >= LEAD3_LO) begin
			need = 2'd2;
		end else begin
			need = 2'd1;
		end
		step_cnt = {1'b0, st.seen_count} + 3'd1;
		v        = {st.partial_value, text_byte[5:0]};
	end

	always_comb begin
		nst            = st;
		burst.count    = '0;
		burst.tail_cp  = REPL_CP;
		burst.tail_rep = 1'b1;
		fresh          = 1'b0;

		if (st.pending) begin
			if (fit) begin
				if (step_cnt >= {1'b0, need}) begin
					nst            = '0;
					burst.count    = 3'd1;
					burst.tail_cp  = v[CP_W-1:0];
					burst.tail_rep = 1'b0;
				end else begin
					nst.seen_count    = step_cnt[1:0];
					nst.partial_value = v[17:0];
				end
			end else begin
				burst.count = {1'b0, st.seen_count} + 3'd1;
				nst         = '0;
				fresh       = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			if (text_byte < ASCII_LIMIT) begin
				burst.count    = burst.count + 3'd1;
				burst.tail_cp  = {13'd0, text_byte};
				burst.tail_rep = 1'b0;
			end else if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI) begin
				nst.pending       = 1'b1;
				nst.lead_byte     = text_byte;
				nst.seen_count    = 2'd0;
				nst.partial_value = {13'd0, text_byte[4:0]};
			end else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI) begin
				nst.pending       = 1'b1;
				nst.lead_byte     = text_byte;
				nst.seen_count    = 2'd0;
				nst.partial_value = {14'd0, text_byte[3:0]};
			end else if (text_byte >= LEAD4_LO && text_byte <= LEAD4_HI) begin
				nst.pending       = 1'b1;
				nst.lead_byte     = text_byte;
				nst.seen_count    = 2'd0;
				nst.partial_value = {15'd0, text_byte[2:0]};
			end else begin
				burst.count    = burst.count + 3'd1;
				burst.tail_cp  = REPL_CP;
				burst.tail_rep = 1'b1;
			end
		end

		if (end_of_text && nst.pending) begin
			burst.count    = burst.count + {1'b0, nst.seen_count} + 3'd1;
			burst.tail_cp  = REPL_CP;
			burst.tail_rep = 1'b1;
			nst            = '0;
		end
	end

endmodule

`default_nettype wire

/* design/sud_checker.sv */
// Port-level checker for the strict UTF-8 decoder and its bind
`default_nettype none

`include "strict_utf8_decoder_assert.svh"

module sud_checker import sud_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic [CP_W-1:0] code_point,
	input wire logic            replaced,
	input wire logic            last_of_run
);

	`SUD_ASSERT_NOW(a_plain_is_last, out_valid && !replaced, last_of_run)
	`SUD_ASSERT_NOW(a_repl_value, out_valid && replaced, code_point == REPL_CP)
	`SUD_ASSERT_NOW(a_scalar_range, out_valid && !replaced,
		(code_point <= MAX_CP) && !((code_point >= SUR_LO) && (code_point <= SUR_HI)))
	`SUD_ASSERT_NOW(a_burst_blocks_input, out_valid && !last_of_run, !in_ready)
	`SUD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind strict_utf8_decoder sud_checker u_sud_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (byte_in.ready),
	.out_valid   (cp_out.valid),
	.out_ready   (cp_out.ready),
	.code_point  (cp_out.code_point),
	.replaced    (cp_out.replaced),
	.last_of_run (cp_out.last_of_run)
);

`default_nettype wire

/* bench/strict_utf8_decoder_test.sv */
// Self-checking testbench of the strict UTF-8 decoder: byte stream in, scoreboarded code points out
`default_nettype none

module strict_utf8_decoder_test;
	import sud_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS   = 440;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 20;

	class cp_scoreboard;
		typedef struct packed {
			logic [CP_W-1:0] code_point;
			logic            replaced;
			logic            last_of_run;
		} cp_item_t;

		logic [7:0]  lead;
		logic [1:0]  seen;
		logic [17:0] partial;
		bit          open_seq;
		cp_item_t    expected_q[$];
		cp_item_t    run_q[$];
		int          errors;

		function new();
			clear_seq();
			errors = 0;
		endfunction

		function void clear_seq();
			lead = '0;
			seen = '0;
			partial = '0;
			open_seq = 1'b0;
		endfunction

		function void emit(logic [CP_W-1:0] cp, logic rep);
			cp_item_t it;
			it.code_point = cp;
			it.replaced = rep;
			it.last_of_run = 1'b0;
			run_q.push_back(it);
		endfunction

		function void flush_open();
			for (int k = 0; k <= int'(seen); k++)
				emit(REPL_CP, 1'b1);
			clear_seq();
		endfunction

		function int unsigned tail_length(logic [7:0] b);
			if (b >= LEAD4_LO)
				return 3;
			if (b >= LEAD3_LO)
				return 2;
			return 1;
		endfunction

		function bit continues(logic [7:0] b);
			if ((b & CONT_MASK) != CONT_TAG)
				return 1'b0;
			if (seen == 2'd0) begin
				if (lead == LEAD3_LO && b < CONT_A0)
					return 1'b0;
				if (lead == LEAD3_SUR && b >= CONT_A0)
					return 1'b0;
				if (lead == LEAD4_LO && b < CONT_90)
					return 1'b0;
				if (lead == LEAD4_HI && b >= CONT_90)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void start_fresh(logic [7:0] b);
			if (b < ASCII_LIMIT) begin
				emit({13'd0, b}, 1'b0);
			end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
				open_seq = 1'b1;
				lead = b;
				seen = '0;
				partial = {13'd0, b[4:0]};
			end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
				open_seq = 1'b1;
				lead = b;
				seen = '0;
				partial = {14'd0, b[3:0]};
			end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
				open_seq = 1'b1;
				lead = b;
				seen = '0;
				partial = {15'd0, b[2:0]};
			end else begin
				emit(REPL_CP, 1'b1);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic eot);
			logic [23:0]  value;
			int unsigned  taken;
			run_q.delete();
			if (open_seq) begin
				if (continues(b)) begin
					value = {partial, b[5:0]};
					taken = int'(seen) + 1;
					if (taken >= tail_length(lead)) begin
						clear_seq();
						emit(value[CP_W-1:0], 1'b0);
					end else begin
						seen = taken[1:0];
						partial = value[17:0];
					end
				end else begin
					flush_open();
					start_fresh(b);
				end
			end else begin
				start_fresh(b);
			end
			if (eot && open_seq)
				flush_open();
			if (run_q.size() > 0)
				run_q[run_q.size()-1].last_of_run = 1'b1;
			foreach (run_q[i])
				expected_q.push_back(run_q[i]);
		endfunction

		function void check_cp(logic [CP_W-1:0] cp, logic rep, logic last);
			cp_item_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected item code_point %h replaced %b last_of_run %b",
					$time, cp, rep, last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (cp !== want.code_point) begin
				$display("%0t: code_point expected %h actual %h", $time, want.code_point, cp);
				errors++;
			end
			if (rep !== want.replaced) begin
				$display("%0t: replaced expected %b actual %b", $time, want.replaced, rep);
				errors++;
			end
			if (last !== want.last_of_run) begin
				$display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run, last);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int unsigned items_sent;
	int unsigned idle_cycles = 0;
	logic [7:0] seq_bytes[$];
	cp_scoreboard sb = new();

	logic [8:0] opening_items [0:27] = '{
		9'h001, 9'h07F, 9'h0E0, 9'h0A0, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0C1,
		9'h0FF, 9'h080, 9'h0E0, 9'h09F, 9'h0ED, 9'h0A0, 9'h0F4, 9'h090, 9'h0F1, 9'h080,
		9'h080, 9'h141, 9'h0E1, 9'h180, 9'h0F2, 9'h080, 9'h080, 9'h1F3
	};

	sud_byte_if byte_ch ();
	sud_cp_if   cp_ch ();

	strict_utf8_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_ch),
		.cp_out (cp_ch)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic void encode_scalar(logic [CP_W-1:0] cp);
		if (cp < 21'h80) begin
			seq_bytes.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			seq_bytes.push_back({3'b110, cp[10:6]});
			seq_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			seq_bytes.push_back({4'b1110, cp[15:12]});
			seq_bytes.push_back({2'b10, cp[11:6]});
			seq_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			seq_bytes.push_back({5'b11110, cp[20:18]});
			seq_bytes.push_back({2'b10, cp[17:12]});
			seq_bytes.push_back({2'b10, cp[11:6]});
			seq_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic logic [CP_W-1:0] random_scalar(int unsigned min_len);
		logic [CP_W-1:0] cp;
		case ($urandom_range(min_len, 4))
			1: cp = CP_W'($urandom_range(1, 'h7F));
			2: cp = CP_W'($urandom_range('h80, 'h7FF));
			3: begin
				cp = CP_W'($urandom_range('h800, 'hFFFF));
				while (cp >= SUR_LO && cp <= SUR_HI)
					cp = CP_W'($urandom_range('h800, 'hFFFF));
			end
			default: cp = CP_W'($urandom_range('h10000, MAX_CP));
		endcase
		return cp;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.text_byte <= b;
		byte_ch.end_of_text <= eot;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_seq(input logic eot_last);
		foreach (seq_bytes[i])
			send_byte(seq_bytes[i], eot_last && (i == seq_bytes.size() - 1));
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	initial begin
		int unsigned run;
		cp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = pick_gap();
			if (run > 0) begin
				cp_ch.ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
			cp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				sb.note_byte(byte_ch.text_byte, byte_ch.end_of_text);
			if (cp_ch.valid && cp_ch.ready)
				sb.check_cp(cp_ch.code_point, cp_ch.replaced, cp_ch.last_of_run);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int unsigned kind;
		int unsigned idx;
		bit          pressed;
		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		pressed = 1'b0;
		items_sent = 0;
		byte_ch.valid = 1'b0;
		byte_ch.text_byte = 8'h00;
		byte_ch.end_of_text = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_items[i])
			send_byte(opening_items[i][7:0], opening_items[i][8]);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = (items_sent >= 150 && items_sent < 230);
			if (!pressed && items_sent >= 300) begin
				wait_drained();
				pressed = 1'b1;
			end
			seq_bytes.delete();
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				encode_scalar(random_scalar(1));
			end else if (kind < 85) begin
				seq_bytes.push_back(8'($urandom_range('h80, 'hFF)));
				repeat ($urandom_range(0, 3))
					seq_bytes.push_back(8'($urandom_range('h80, 'hBF)));
			end else if (kind < 93) begin
				encode_scalar(random_scalar(2));
				idx = $urandom_range(1, seq_bytes.size() - 1);
				seq_bytes[idx] = 8'($urandom_range(1, 255));
			end else begin
				seq_bytes.push_back(8'($urandom_range(1, 255)));
			end
			send_seq($urandom_range(0, 7) == 0);
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/sud_pkg.sv
design/sud_ifs.sv
design/sud_decode.sv
design/strict_utf8_decoder.sv
design/sud_checker.sv
bench/strict_utf8_decoder_test.sv
